// File: design/ttt_pkg.sv
// Shared types and constants for the top-talker tracker.
// Used by ttt_cell, wifi_top_talker_tracker_top and the testbench; no dependencies.
package ttt_pkg;

	localparam int ADDR_W = 48;
	localparam int CNT_W  = 32;
	localparam int IDX_W  = 4;
	localparam int LVL_W  = 2;
	localparam int OP_W   = 2;
	localparam int REG_W  = 2;

	// operations
	localparam logic [OP_W-1:0] OP_FRAME = 2'd0;
	localparam logic [OP_W-1:0] OP_READ  = 2'd1;
	localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

	// configuration register indexes
	localparam logic [REG_W-1:0] REG_CAPTURE = 2'd0;
	localparam logic [REG_W-1:0] REG_FLOOD   = 2'd1;
	localparam logic [REG_W-1:0] REG_HIGH    = 2'd2;

	localparam logic [CNT_W-1:0] FLOOD_RST = 32'd100000;
	localparam logic [CNT_W-1:0] HIGH_RST  = 32'd50000;

	// 802.11 frame types
	localparam logic [1:0] TYPE_MGMT = 2'd0;
	localparam logic [1:0] TYPE_DATA = 2'd2;
	localparam logic [15:0] MIN_LEN  = 16'd24;

	// traffic levels
	localparam logic [LVL_W-1:0] LVL_NORMAL = 2'd0;
	localparam logic [LVL_W-1:0] LVL_HIGH   = 2'd1;
	localparam logic [LVL_W-1:0] LVL_FLOOD  = 2'd2;

	// command broadcast to every cell
	typedef struct packed {
		logic              clear;
		logic              match;
		logic              append;
		logic              sweep;
		logic [ADDR_W-1:0] key;
	} cell_ctrl_t;

endpackage

// File: design/ttt_cell.sv
// One rank of the tracker table: address, count and hit mark, plus one
// stage of the read-out chain. Depends on ttt_pkg.
module ttt_cell #(
	parameter int TABLE_ENTRIES = 10,
	parameter int RANK = 0
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  ttt_pkg::cell_ctrl_t                ctrl,
	input  logic [$clog2(TABLE_ENTRIES+1)-1:0] step,
	input  logic [$clog2(TABLE_ENTRIES+1)-1:0] wr_rank,
	input  logic [$clog2(TABLE_ENTRIES+1)-1:0] used,
	input  logic [ttt_pkg::IDX_W-1:0]          rd_rank,
	input  logic [ttt_pkg::ADDR_W-1:0]         up_addr,
	input  logic [ttt_pkg::CNT_W-1:0]          up_count,
	input  logic [ttt_pkg::ADDR_W-1:0]         dn_addr,
	input  logic [ttt_pkg::CNT_W-1:0]          dn_count,
	input  logic                               dn_swap,
	input  logic [ttt_pkg::ADDR_W-1:0]         rd_in_addr,
	input  logic [ttt_pkg::CNT_W-1:0]          rd_in_count,
	output logic [ttt_pkg::ADDR_W-1:0]         addr,
	output logic [ttt_pkg::CNT_W-1:0]          count,
	output logic                               hit,
	output logic                               swap_up,
	output logic [ttt_pkg::ADDR_W-1:0]         rd_addr,
	output logic [ttt_pkg::CNT_W-1:0]          rd_count
);

	localparam int UW = $clog2(TABLE_ENTRIES + 1);
	localparam int CW = (UW > ttt_pkg::IDX_W) ? UW : ttt_pkg::IDX_W;

	logic [ttt_pkg::ADDR_W-1:0] addr_q;
	logic [ttt_pkg::CNT_W-1:0]  count_q;
	logic                       hit_q;
	logic [ttt_pkg::ADDR_W-1:0] rd_addr_q;
	logic [ttt_pkg::CNT_W-1:0]  rd_count_q;
	logic                       occupied;
	logic                       match_hit;
	logic                       at_lo;
	logic                       at_hi;

	assign occupied  = UW'(RANK) < used;
	assign match_hit = occupied && (addr_q == ctrl.key);
	// pair under the sweep is (step, step-1)
	assign at_lo     = step == UW'(RANK);
	assign at_hi     = step == UW'(RANK + 1);
	assign swap_up   = (RANK != 0) && hit_q && (count_q > up_count);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q  <= '0;
			count_q <= '0;
			hit_q   <= 1'b0;
		end else if (ctrl.clear) begin
			addr_q  <= '0;
			count_q <= '0;
			hit_q   <= 1'b0;
		end else if (ctrl.match) begin
			hit_q <= match_hit;
			if (match_hit && (count_q != '1)) begin
				count_q <= count_q + 1'b1;
			end
		end else if (ctrl.append) begin
			if (wr_rank == UW'(RANK)) begin
				addr_q  <= ctrl.key;
				count_q <= ttt_pkg::CNT_W'(1);
			end
		end else if (ctrl.sweep) begin
			if (at_lo && swap_up) begin
				addr_q  <= up_addr;
				count_q <= up_count;
				hit_q   <= 1'b0;
			end else if (at_hi && dn_swap) begin
				addr_q  <= dn_addr;
				count_q <= dn_count;
				hit_q   <= 1'b1;
			end
		end
	end

	// read-out chain: the selected rank injects, everyone else forwards
	always_ff @(posedge clk) begin
		if (CW'(rd_rank) == CW'(RANK)) begin
			rd_addr_q  <= addr_q;
			rd_count_q <= count_q;
		end else begin
			rd_addr_q  <= rd_in_addr;
			rd_count_q <= rd_in_count;
		end
	end

	assign addr     = addr_q;
	assign count    = count_q;
	assign hit      = hit_q;
	assign rd_addr  = rd_addr_q;
	assign rd_count = rd_count_q;

endmodule

// File: design/wifi_top_talker_tracker_top.sv
// Top level of the top-talker tracker: control sequencer, totals,
// configuration registers and the row of ttt_cell ranks. Depends on ttt_pkg.
//
//  channel  signals                               transfer when
//  in       in_valid/in_ready + item fields       in_valid & in_ready
//  out      out_valid/out_ready + result fields   out_valid & out_ready
//  cfg      cfg_we, cfg_addr, cfg_wdata           cfg_we
//
// One item at a time. A frame with a table hit runs the bubble sweep, which
// walks one adjacent pair of ranks per cycle from the bottom pair up to the
// top pair. A table read shifts the entry out along the read-out chain.
// Reset clears table and totals and loads the default thresholds at once.
// A pending result sits in the output register; the next item is taken
// meanwhile and waits in its final state until the result slot frees.
module wifi_top_talker_tracker_top #(
	parameter int TABLE_ENTRIES = 10
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [ttt_pkg::OP_W-1:0]      operation,
	input  logic [15:0]                   frame_control,
	input  logic [15:0]                   frame_length,
	input  logic [ttt_pkg::ADDR_W-1:0]    second_address,
	input  logic [ttt_pkg::ADDR_W-1:0]    third_address,
	input  logic [ttt_pkg::IDX_W-1:0]     entry_index,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          frame_counted,
	output logic                          source_tracked,
	output logic [ttt_pkg::CNT_W-1:0]     total_frames,
	output logic [ttt_pkg::LVL_W-1:0]     traffic_level,
	output logic [ttt_pkg::IDX_W-1:0]     entries_in_use,
	output logic                          entry_valid,
	output logic [ttt_pkg::ADDR_W-1:0]    entry_address,
	output logic [ttt_pkg::CNT_W-1:0]     entry_count,
	input  logic                          cfg_we,
	input  logic [ttt_pkg::REG_W-1:0]     cfg_addr,
	input  logic [ttt_pkg::CNT_W-1:0]     cfg_wdata
);

	localparam int UW = $clog2(TABLE_ENTRIES + 1);
	localparam int CW = (UW > ttt_pkg::IDX_W) ? UW : ttt_pkg::IDX_W;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_EXEC  = 3'd1;
	localparam logic [2:0] ST_PLACE = 3'd2;
	localparam logic [2:0] ST_SWEEP = 3'd3;
	localparam logic [2:0] ST_READ  = 3'd4;
	localparam logic [2:0] ST_FIN   = 3'd5;

	logic [2:0]                  state_q;
	logic [UW-1:0]               step_q;
	logic [UW-1:0]               used_q;
	logic [ttt_pkg::CNT_W-1:0]   total_q;
	logic                        capture_q;
	logic [ttt_pkg::CNT_W-1:0]   flood_q;
	logic [ttt_pkg::CNT_W-1:0]   high_q;

	logic [ttt_pkg::OP_W-1:0]    op_q;
	logic [ttt_pkg::IDX_W-1:0]   idx_q;
	logic [ttt_pkg::ADDR_W-1:0]  key_q;
	logic                        frame_ok_q;
	logic                        track_ok_q;
	logic                        counted_q;
	logic                        tracked_q;

	logic                        out_valid_q;
	logic                        frame_counted_q;
	logic                        source_tracked_q;
	logic [ttt_pkg::CNT_W-1:0]   total_frames_q;
	logic [ttt_pkg::LVL_W-1:0]   traffic_level_q;
	logic [ttt_pkg::IDX_W-1:0]   entries_in_use_q;
	logic                        entry_valid_q;
	logic [ttt_pkg::ADDR_W-1:0]  entry_address_q;
	logic [ttt_pkg::CNT_W-1:0]   entry_count_q;

	logic                        accept;
	logic                        out_free;
	logic                        any_hit;
	logic                        read_ok;
	logic [1:0]                  ftype;
	logic [ttt_pkg::ADDR_W-1:0]  src;
	logic [UW-1:0]               wr_rank;
	ttt_pkg::cell_ctrl_t         ctrl;
	logic [ttt_pkg::LVL_W-1:0]   level;

	logic [ttt_pkg::ADDR_W-1:0]  cell_addr  [TABLE_ENTRIES];
	logic [ttt_pkg::CNT_W-1:0]   cell_count [TABLE_ENTRIES];
	logic [TABLE_ENTRIES-1:0]    cell_hit;
	logic [TABLE_ENTRIES-1:0]    cell_swap;
	logic [ttt_pkg::ADDR_W-1:0]  rd_addr    [TABLE_ENTRIES];
	logic [ttt_pkg::CNT_W-1:0]   rd_count   [TABLE_ENTRIES];

	assign in_ready = state_q == ST_IDLE;
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign any_hit  = |cell_hit;
	assign read_ok  = (op_q == ttt_pkg::OP_READ) && (CW'(idx_q) < CW'(used_q));

	// type in bits 3:2, fromDS in bit 9; data frames with fromDS set use address 3
	assign ftype = frame_control[3:2];
	assign src   = ((ftype == ttt_pkg::TYPE_DATA) && frame_control[9]) ?
		third_address : second_address;

	assign wr_rank = (used_q < UW'(TABLE_ENTRIES)) ? used_q : UW'(TABLE_ENTRIES - 1);

	always_comb begin
		ctrl.clear  = (state_q == ST_EXEC) && (op_q == ttt_pkg::OP_CLEAR);
		ctrl.match  = (state_q == ST_EXEC) && (op_q == ttt_pkg::OP_FRAME) && track_ok_q;
		ctrl.append = (state_q == ST_PLACE) && !any_hit;
		ctrl.sweep  = state_q == ST_SWEEP;
		ctrl.key    = key_q;
	end

	always_comb begin
		if (total_q > flood_q) begin
			level = ttt_pkg::LVL_FLOOD;
		end else if (total_q > high_q) begin
			level = ttt_pkg::LVL_HIGH;
		end else begin
			level = ttt_pkg::LVL_NORMAL;
		end
	end

	// item fields, latched at transfer
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q       <= operation;
			idx_q      <= entry_index;
			key_q      <= src;
			frame_ok_q <= capture_q && (frame_length >= ttt_pkg::MIN_LEN);
			track_ok_q <= capture_q && (frame_length >= ttt_pkg::MIN_LEN) &&
				((ftype == ttt_pkg::TYPE_MGMT) || (ftype == ttt_pkg::TYPE_DATA)) &&
				!src[40];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			step_q    <= '0;
			used_q    <= '0;
			total_q   <= '0;
			counted_q <= 1'b0;
			tracked_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					counted_q <= 1'b0;
					tracked_q <= 1'b0;
					case (op_q)
						ttt_pkg::OP_FRAME: begin
							if (frame_ok_q && (total_q != '1)) begin
								total_q   <= total_q + 1'b1;
								counted_q <= 1'b1;
							end
							tracked_q <= track_ok_q;
							state_q   <= track_ok_q ? ST_PLACE : ST_FIN;
						end
						ttt_pkg::OP_READ: begin
							step_q  <= '0;
							state_q <= ST_READ;
						end
						ttt_pkg::OP_CLEAR: begin
							total_q <= '0;
							used_q  <= '0;
							state_q <= ST_FIN;
						end
						default: begin
							state_q <= ST_FIN;
						end
					endcase
				end
				ST_PLACE: begin
					if (any_hit) begin
						step_q  <= UW'(TABLE_ENTRIES - 1);
						state_q <= ST_SWEEP;
					end else begin
						if (used_q < UW'(TABLE_ENTRIES)) begin
							used_q <= used_q + 1'b1;
						end
						state_q <= ST_FIN;
					end
				end
				ST_SWEEP: begin
					// bottom pair up to the (1,0) pair
					if (step_q == UW'(1)) begin
						state_q <= ST_FIN;
					end else begin
						step_q <= step_q - 1'b1;
					end
				end
				ST_READ: begin
					// the chain shifts until the selected entry reaches the last rank
					if (step_q == UW'(TABLE_ENTRIES)) begin
						state_q <= ST_FIN;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_FIN) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_FIN) && out_free) begin
			frame_counted_q  <= counted_q;
			source_tracked_q <= tracked_q;
			total_frames_q   <= total_q;
			traffic_level_q  <= level;
			entries_in_use_q <= ttt_pkg::IDX_W'(used_q);
			entry_valid_q    <= read_ok;
			entry_address_q  <= read_ok ? rd_addr[TABLE_ENTRIES-1] : '0;
			entry_count_q    <= read_ok ? rd_count[TABLE_ENTRIES-1] : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capture_q <= 1'b0;
			flood_q   <= ttt_pkg::FLOOD_RST;
			high_q    <= ttt_pkg::HIGH_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				ttt_pkg::REG_CAPTURE: capture_q <= cfg_wdata[0];
				ttt_pkg::REG_FLOOD:   flood_q   <= cfg_wdata;
				ttt_pkg::REG_HIGH:    high_q    <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	genvar gi;
	generate
		for (gi = 0; gi < TABLE_ENTRIES; gi++) begin : g_rank
			logic [ttt_pkg::ADDR_W-1:0] up_addr;
			logic [ttt_pkg::CNT_W-1:0]  up_count;
			logic [ttt_pkg::ADDR_W-1:0] dn_addr;
			logic [ttt_pkg::CNT_W-1:0]  dn_count;
			logic                       dn_swap;
			logic [ttt_pkg::ADDR_W-1:0] rd_in_addr;
			logic [ttt_pkg::CNT_W-1:0]  rd_in_count;

			if (gi == 0) begin : g_first
				assign up_addr     = '0;
				assign up_count    = '0;
				assign rd_in_addr  = '0;
				assign rd_in_count = '0;
			end else begin : g_inner_up
				assign up_addr     = cell_addr[gi-1];
				assign up_count    = cell_count[gi-1];
				assign rd_in_addr  = rd_addr[gi-1];
				assign rd_in_count = rd_count[gi-1];
			end

			if (gi == TABLE_ENTRIES - 1) begin : g_last
				assign dn_addr  = '0;
				assign dn_count = '0;
				assign dn_swap  = 1'b0;
			end else begin : g_inner_dn
				assign dn_addr  = cell_addr[gi+1];
				assign dn_count = cell_count[gi+1];
				assign dn_swap  = cell_swap[gi+1];
			end

			ttt_cell #(
				.TABLE_ENTRIES(TABLE_ENTRIES),
				.RANK(gi)
			) u_cell (
				.clk         (clk),
				.arst_n      (arst_n),
				.ctrl        (ctrl),
				.step        (step_q),
				.wr_rank     (wr_rank),
				.used        (used_q),
				.rd_rank     (idx_q),
				.up_addr     (up_addr),
				.up_count    (up_count),
				.dn_addr     (dn_addr),
				.dn_count    (dn_count),
				.dn_swap     (dn_swap),
				.rd_in_addr  (rd_in_addr),
				.rd_in_count (rd_in_count),
				.addr        (cell_addr[gi]),
				.count       (cell_count[gi]),
				.hit         (cell_hit[gi]),
				.swap_up     (cell_swap[gi]),
				.rd_addr     (rd_addr[gi]),
				.rd_count    (rd_count[gi])
			);
		end
	endgenerate

	assign out_valid      = out_valid_q;
	assign frame_counted  = frame_counted_q;
	assign source_tracked = source_tracked_q;
	assign total_frames   = total_frames_q;
	assign traffic_level  = traffic_level_q;
	assign entries_in_use = entries_in_use_q;
	assign entry_valid    = entry_valid_q;
	assign entry_address  = entry_address_q;
	assign entry_count    = entry_count_q;

	// occupancy never passes the table size
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= UW'(TABLE_ENTRIES))
		else $error("occupancy above table size");

	// the sweep always carries exactly one marked entry
	a_sweep_one_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SWEEP) |-> $onehot(cell_hit))
		else $error("sweep without a single hit mark");

	// a counted frame always reports a nonzero total
	a_counted_total: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && frame_counted_q) |-> (total_frames_q != '0))
		else $error("counted frame with zero total");

	// a result is loaded only once the slot is free
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready && (state_q == ST_FIN)) |=> (state_q == ST_FIN))
		else $error("sequencer left final state with result slot busy");

endmodule

// File: sim/tb_wifi_top_talker_tracker_top.sv
// Self-checking testbench for wifi_top_talker_tracker_top: drives frame, read and clear
// items, predicts each status result and compares it field by field. Depends on ttt_pkg.
module tb_wifi_top_talker_tracker_top;
	timeunit 1ns;
	timeprecision 1ps;

	import ttt_pkg::*;

	localparam int CLK_PERIOD     = 10;
	localparam int TABLE_ENTRIES  = 10;
	localparam int POOL_SIZE      = 14;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int FC_TO_DS       = 8;
	localparam int FC_FROM_DS     = 9;
	localparam int GROUP_BIT      = 40;

	localparam logic [OP_W-1:0]  OP_UNUSED  = 2'd3;
	localparam logic [REG_W-1:0] REG_UNUSED = 2'd3;
	localparam logic [1:0]       TYPE_CTRL  = 2'd1;
	localparam logic [1:0]       TYPE_EXT   = 2'd3;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [15:0]       fc;
		logic [15:0]       len;
		logic [ADDR_W-1:0] a2;
		logic [ADDR_W-1:0] a3;
		logic [IDX_W-1:0]  idx;
	} talker_item_t;

	typedef struct packed {
		logic              counted;
		logic              tracked;
		logic [CNT_W-1:0]  total;
		logic [LVL_W-1:0]  level;
		logic [IDX_W-1:0]  in_use;
		logic              valid;
		logic [ADDR_W-1:0] addr;
		logic [CNT_W-1:0]  count;
	} talker_status_t;

	logic                clk            = 1'b0;
	logic                arst_n         = 1'b0;
	logic                in_valid       = 1'b0;
	logic                in_ready;
	logic [OP_W-1:0]     operation      = '0;
	logic [15:0]         frame_control  = '0;
	logic [15:0]         frame_length   = '0;
	logic [ADDR_W-1:0]   second_address = '0;
	logic [ADDR_W-1:0]   third_address  = '0;
	logic [IDX_W-1:0]    entry_index    = '0;
	logic                out_valid;
	logic                out_ready      = 1'b0;
	logic                frame_counted;
	logic                source_tracked;
	logic [CNT_W-1:0]    total_frames;
	logic [LVL_W-1:0]    traffic_level;
	logic [IDX_W-1:0]    entries_in_use;
	logic                entry_valid;
	logic [ADDR_W-1:0]   entry_address;
	logic [CNT_W-1:0]    entry_count;
	logic                cfg_we         = 1'b0;
	logic [REG_W-1:0]    cfg_addr       = '0;
	logic [CNT_W-1:0]    cfg_wdata      = '0;

	// predictor copy of the rank table, totals and registers
	logic [ADDR_W-1:0]   rank_addr [TABLE_ENTRIES];
	logic [CNT_W-1:0]    rank_hits [TABLE_ENTRIES];
	logic [IDX_W-1:0]    ranks_used;
	logic [CNT_W-1:0]    frame_tally;
	logic                capture_on;
	logic [CNT_W-1:0]    flood_limit;
	logic [CNT_W-1:0]    high_limit;

	logic [ADDR_W-1:0]   talker_pool [POOL_SIZE];
	talker_status_t      pending_status [$];
	talker_status_t      want_status;
	int                  error_count        = 0;
	int                  quiet_cycles       = 0;
	int                  sender_idle_pct    = 0;
	int                  receiver_stall_pct = 0;
	int                  hold_left          = 0;

	wifi_top_talker_tracker_top #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.operation(operation),
		.frame_control(frame_control),
		.frame_length(frame_length),
		.second_address(second_address),
		.third_address(third_address),
		.entry_index(entry_index),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.frame_counted(frame_counted),
		.source_tracked(source_tracked),
		.total_frames(total_frames),
		.traffic_level(traffic_level),
		.entries_in_use(entries_in_use),
		.entry_valid(entry_valid),
		.entry_address(entry_address),
		.entry_count(entry_count),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic logic [ADDR_W-1:0] rand48();
		logic [63:0] r;
		r = {$urandom, $urandom};
		return r[ADDR_W-1:0];
	endfunction

	function automatic void clear_talkers();
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			rank_addr[i] = '0;
			rank_hits[i] = '0;
		end
		ranks_used  = '0;
		frame_tally = '0;
	endfunction

	// hit: count up and bubble past strictly smaller counts; miss: append or take last rank
	function automatic void track_talker(input logic [ADDR_W-1:0] src);
		int r;
		logic [ADDR_W-1:0] ta;
		logic [CNT_W-1:0] tc;
		for (r = 0; r < ranks_used; r++) begin
			if (rank_addr[r] == src) begin
				if (rank_hits[r] != '1)
					rank_hits[r] = rank_hits[r] + 1'b1;
				while (r > 0 && rank_hits[r] > rank_hits[r-1]) begin
					ta = rank_addr[r];
					tc = rank_hits[r];
					rank_addr[r]   = rank_addr[r-1];
					rank_hits[r]   = rank_hits[r-1];
					rank_addr[r-1] = ta;
					rank_hits[r-1] = tc;
					r--;
				end
				return;
			end
		end
		if (ranks_used < TABLE_ENTRIES) begin
			rank_addr[ranks_used] = src;
			rank_hits[ranks_used] = 1;
			ranks_used = ranks_used + 1'b1;
		end else begin
			rank_addr[TABLE_ENTRIES-1] = src;
			rank_hits[TABLE_ENTRIES-1] = 1;
		end
	endfunction

	function automatic talker_status_t predict_talker_status(input talker_item_t it);
		talker_status_t st;
		logic [ADDR_W-1:0] src;
		logic [1:0] ftype;
		st = '0;
		ftype = it.fc[3:2];
		case (it.op)
			OP_FRAME: begin
				if (capture_on && it.len >= MIN_LEN) begin
					// a saturated total still lets the frame be tracked
					if (frame_tally != '1) begin
						frame_tally = frame_tally + 1'b1;
						st.counted = 1'b1;
					end
					if (ftype == TYPE_MGMT || ftype == TYPE_DATA) begin
						src = (ftype == TYPE_DATA && it.fc[FC_FROM_DS]) ? it.a3 : it.a2;
						if (!src[GROUP_BIT]) begin
							track_talker(src);
							st.tracked = 1'b1;
						end
					end
				end
			end
			OP_READ: begin
				if (it.idx < ranks_used) begin
					st.valid = 1'b1;
					st.addr  = rank_addr[it.idx];
					st.count = rank_hits[it.idx];
				end
			end
			OP_CLEAR: clear_talkers();
			default: ;
		endcase
		st.total  = frame_tally;
		st.in_use = ranks_used;
		if (frame_tally > flood_limit)
			st.level = LVL_FLOOD;
		else if (frame_tally > high_limit)
			st.level = LVL_HIGH;
		else
			st.level = LVL_NORMAL;
		return st;
	endfunction

	function automatic talker_item_t frame_item(input logic [1:0] ftype, input logic to_ds,
			input logic from_ds, input logic [15:0] len, input logic [ADDR_W-1:0] a2,
			input logic [ADDR_W-1:0] a3);
		talker_item_t it;
		it.op  = OP_FRAME;
		it.fc  = $urandom;
		it.fc[3:2] = ftype;
		it.fc[FC_TO_DS] = to_ds;
		it.fc[FC_FROM_DS] = from_ds;
		it.len = len;
		it.a2  = a2;
		it.a3  = a3;
		it.idx = $urandom;
		return it;
	endfunction

	function automatic talker_item_t op_item(input logic [OP_W-1:0] op,
			input logic [IDX_W-1:0] idx);
		talker_item_t it;
		it.op  = op;
		it.fc  = $urandom;
		it.len = $urandom;
		it.a2  = rand48();
		it.a3  = rand48();
		it.idx = idx;
		return it;
	endfunction

	// mostly well-formed frames from a small set of hot talkers, some reads, rare clears
	function automatic talker_item_t random_talker_item();
		talker_item_t it;
		int pick;
		logic [ADDR_W-1:0] src;
		logic [1:0] ftype;
		it = op_item(OP_FRAME, $urandom);
		pick = $urandom_range(999);
		if (pick < 15) begin
			it.op = OP_CLEAR;
		end else if (pick < 30) begin
			it.op = OP_UNUSED;
		end else if (pick < 150) begin
			it.op = OP_READ;
			if ($urandom_range(3) != 0)
				it.idx = $urandom_range(ranks_used);
		end else begin
			pick = $urandom_range(99);
			ftype = (pick < 45) ? TYPE_MGMT : (pick < 90) ? TYPE_DATA :
				(pick < 95) ? TYPE_CTRL : TYPE_EXT;
			it.fc[3:2] = ftype;
			pick = $urandom_range(99);
			if (pick < 90)
				it.len = $urandom_range(2346, 24);
			else if (pick < 95)
				it.len = $urandom_range(23);
			if ($urandom_range(9) < 2)
				src = rand48();
			else if ($urandom_range(1))
				src = talker_pool[$urandom_range(3)];
			else
				src = talker_pool[$urandom_range(POOL_SIZE-1)];
			if (ftype == TYPE_DATA && it.fc[FC_FROM_DS])
				it.a3 = src;
			else
				it.a2 = src;
		end
		return it;
	endfunction

	// called at a falling edge; returns at the falling edge after the transfer
	task automatic send_item(input talker_item_t it);
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid       <= 1'b1;
		operation      <= it.op;
		frame_control  <= it.fc;
		frame_length   <= it.len;
		second_address <= it.a2;
		third_address  <= it.a3;
		entry_index    <= it.idx;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		pending_status.push_back(predict_talker_status(it));
		@(negedge clk);
	endtask

	task automatic send_random_items(input int n);
		for (int i = 0; i < n; i++)
			send_item(random_talker_item());
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_status.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_talker_reg(input logic [REG_W-1:0] idx, input logic [CNT_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= val;
		case (idx)
			REG_CAPTURE: capture_on = val[0];
			REG_FLOOD: flood_limit = val;
			REG_HIGH: high_limit = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			error_count++;
		end
	endtask

	task automatic test_reset_state();
		// capture is off after reset, so the frame must leave everything untouched
		send_item(frame_item(TYPE_MGMT, 1'b0, 1'b0, 16'd64, talker_pool[0], rand48()));
		send_item(op_item(OP_READ, '0));
		send_item(op_item(OP_UNUSED, '1));
	endtask

	task automatic test_frame_filtering();
		wait_drained();
		write_talker_reg(REG_CAPTURE, 32'd1);
		send_item(frame_item(TYPE_MGMT, 1'b0, 1'b0, MIN_LEN - 1'b1, talker_pool[0], rand48()));
		send_item(frame_item(TYPE_MGMT, 1'b0, 1'b0, 16'd0, talker_pool[0], rand48()));
		send_item(frame_item(TYPE_MGMT, 1'b0, 1'b0, MIN_LEN, talker_pool[0], rand48()));
		send_item(frame_item(TYPE_CTRL, 1'b0, 1'b0, 16'hFFFF, talker_pool[1], rand48()));
		send_item(frame_item(TYPE_EXT, 1'b1, 1'b1, 16'd100, talker_pool[1], talker_pool[1]));
		send_item(frame_item(TYPE_DATA, 1'b1, 1'b0, 16'd64, talker_pool[1], talker_pool[2]));
		send_item(frame_item(TYPE_DATA, 1'b0, 1'b1, 16'd64, talker_pool[0], talker_pool[2]));
		// four-address frame takes the third address and moves ahead
		send_item(frame_item(TYPE_DATA, 1'b1, 1'b1, 16'd64, talker_pool[0], talker_pool[1]));
		// management frames ignore fromDS
		send_item(frame_item(TYPE_MGMT, 1'b0, 1'b1, 16'd64, talker_pool[2], talker_pool[0]));
		send_item(frame_item(TYPE_MGMT, 1'b0, 1'b0, 16'd64,
			rand48() | (48'd1 << GROUP_BIT), rand48()));
		send_item(frame_item(TYPE_MGMT, 1'b0, 1'b0, 16'd64, '0, '1));
		send_item(op_item(OP_READ, '0));
		send_item(op_item(OP_READ, '1));
	endtask

	task automatic test_table_overflow();
		// fill past the last rank so new talkers overwrite it
		for (int i = 3; i <= 10; i++)
			send_item(frame_item(TYPE_MGMT, 1'b0, 1'b0, 16'd128, talker_pool[i], rand48()));
		send_item(op_item(OP_READ, TABLE_ENTRIES - 1));
		send_item(op_item(OP_READ, TABLE_ENTRIES));
		send_item(op_item(OP_CLEAR, $urandom));
		send_item(op_item(OP_READ, '0));
	endtask

	task automatic test_config_extremes();
		logic [CNT_W-1:0] flood_set [4];
		logic [CNT_W-1:0] high_set [4];
		flood_set = '{'1, '0, '0, '1};
		high_set  = '{'0, '1, '0, '1};
		for (int i = 0; i < 4; i++) begin
			wait_drained();
			write_talker_reg(REG_FLOOD, flood_set[i]);
			write_talker_reg(REG_HIGH, high_set[i]);
			send_random_items(12);
		end
		// capture is bit 0 only; the unused index must be ignored
		wait_drained();
		write_talker_reg(REG_CAPTURE, 32'hFFFF_FFFE);
		write_talker_reg(REG_UNUSED, '1);
		send_random_items(12);
		wait_drained();
		write_talker_reg(REG_CAPTURE, 32'hFFFF_FFFF);
	endtask

	task automatic test_random_traffic();
		int sender_pct [4];
		int receiver_pct [4];
		sender_pct   = '{0, 68, 0, 15};
		receiver_pct = '{0, 0, 68, 15};
		for (int i = 0; i < 4; i++) begin
			wait_drained();
			// thresholds near the running total so the level moves during the phase
			write_talker_reg(REG_HIGH, $urandom_range(frame_tally + 150));
			write_talker_reg(REG_FLOOD, $urandom_range(frame_tally + 150));
			write_talker_reg(REG_CAPTURE, 32'd1);
			sender_idle_pct    = sender_pct[i];
			receiver_stall_pct = receiver_pct[i];
			send_random_items(200);
		end
	endtask

	task automatic test_input_backpressure();
		wait_drained();
		sender_idle_pct    = 0;
		receiver_stall_pct = 0;
		hold_left          = 300;
		send_random_items(30);
	endtask

	// receiver side: random stalls, plus a long hold-off on request
	initial begin
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else begin
				out_ready <= ($urandom_range(99) >= receiver_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_status.size() == 0) begin
				$error("result transfer with no status pending");
				error_count++;
			end else begin
				want_status = pending_status.pop_front();
				check_field("frame_counted", want_status.counted, frame_counted);
				check_field("source_tracked", want_status.tracked, source_tracked);
				check_field("total_frames", want_status.total, total_frames);
				check_field("traffic_level", want_status.level, traffic_level);
				check_field("entries_in_use", want_status.in_use, entries_in_use);
				check_field("entry_valid", want_status.valid, entry_valid);
				check_field("entry_address", want_status.addr, entry_address);
				check_field("entry_count", want_status.count, entry_count);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		clear_talkers();
		capture_on  = 1'b0;
		flood_limit = FLOOD_RST;
		high_limit  = HIGH_RST;
		for (int i = 0; i < POOL_SIZE; i++) begin
			talker_pool[i] = rand48();
			talker_pool[i][GROUP_BIT] = 1'b0;
			talker_pool[i][7:0] = i + 1;
		end
		talker_pool[POOL_SIZE-2] = 48'hFEFF_FFFF_FFFF;
		talker_pool[POOL_SIZE-1] = '0;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_reset_state();
		test_frame_filtering();
		test_table_overflow();
		test_config_extremes();
		test_random_traffic();
		test_input_backpressure();
		wait_drained();
		repeat (40) @(posedge clk);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
